### src/psc_pkg.sv
package psc_pkg;

  // Field and port widths
  localparam int CFG_IDX_W   = 3;
  localparam int COEFF_W     = 16;
  localparam int RAW_W       = 24;
  localparam int IN_TDATA_W  = 48;
  localparam int TOUT_W      = 15;
  localparam int POUT_W      = 18;
  localparam int OUT_TDATA_W = 40;

  // Internal datapath widths
  localparam int DT_W      = 25;  // D2 - C5*256
  localparam int PT_W      = 42;  // dT times a coefficient
  localparam int DT2_W     = 50;  // dT squared
  localparam int TEMP_W    = 20;  // temperature before saturation
  localparam int T2_W      = 18;  // second-order temperature term
  localparam int WIDE_W    = 42;  // OFF, SENS and their corrections
  localparam int SQ_W      = 40;  // squared temperature deltas
  localparam int SENS_LO_W = 20;  // low split of SENS for the pressure product
  localparam int SENS_HI_W = WIDE_W - SENS_LO_W;
  localparam int PP_LO_W   = RAW_W + SENS_LO_W;
  localparam int PP_HI_W   = RAW_W + 1 + SENS_HI_W;
  localparam int PROD_W    = 66;
  localparam int SCALED_W  = 45;
  localparam int DIFF_W    = 46;
  localparam int PSHIFT_W  = 31;

  // Scaling shifts
  localparam int TREF_SHIFT    = 8;
  localparam int TEMP_SHIFT    = 23;
  localparam int OFF_SHIFT     = 17;
  localparam int OFF_TC_SHIFT  = 6;
  localparam int SENS_SHIFT    = 16;
  localparam int SENS_TC_SHIFT = 7;
  localparam int T2_SHIFT      = 31;
  localparam int OFF2_SHIFT    = 4;
  localparam int PROD_SHIFT    = 21;
  localparam int PRESS_SHIFT   = 15;

  // Pipeline depth of each section
  localparam int FRONT_STAGES = 3;
  localparam int CORR_STAGES  = 4;
  localparam int PRESS_STAGES = 3;

  // Temperature thresholds and second-order gains
  localparam logic signed [TEMP_W-1:0] TEMP_REF     = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD    = -20'sd1500;
  localparam logic signed [TEMP_W-1:0] TEMP_OUT_MIN = -20'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_OUT_MAX = 20'sd8500;
  localparam logic [POUT_W-1:0]        PRESS_OUT_MAX = '1;

  localparam logic [WIDE_W-1:0] OFF2_GAIN       = 42'd61;
  localparam logic [WIDE_W-1:0] OFF2_COLD_GAIN  = 42'd20;
  localparam logic [WIDE_W-1:0] SENS2_COLD_GAIN = 42'd12;

  // Calibration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SENS_TC   = 3'd2,
    REG_OFFSET_TC = 3'd3,
    REG_TREF      = 3'd4,
    REG_TEMP_TC   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [COEFF_W-1:0] c1;
    logic [COEFF_W-1:0] c2;
    logic [COEFF_W-1:0] c3;
    logic [COEFF_W-1:0] c4;
    logic [COEFF_W-1:0] c5;
    logic [COEFF_W-1:0] c6;
  } calib_t;

  // First-order results
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic [T2_W-1:0]          t2;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
  } front_t;

  // Second-order compensated values
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
  } comp_t;

endpackage

### src/pressure_sensor_compensation_core.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid/s_axis_tready    raw pressure, raw temperature
// m_axis    out        m_axis_tvalid/m_axis_tready    temperature (0.01 C), pressure (0.01 mbar)
// cfg       in         cfg_valid_i/cfg_ready_o        calibration word index and value
//
// One request per cycle is accepted while m_axis is not stalled; each result
// passes through 3 first-order, 4 second-order correction and 3 pressure stages.
// Each multiplier sits in its own stage: dT products, squares, D1*SENS.
// Reset clears the calibration words and all stage valid bits.
// Every stage holds its data while the next one is full, so a stall on
// m_axis backs up only as far as needed; empty stages keep filling.
module pressure_sensor_compensation_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [psc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [14:0] temperature_centi, [32:15] pressure_centi_mbar, [39:33] zero
  output logic [psc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [psc_pkg::COEFF_W-1:0]     cfg_data_i
);
  import psc_pkg::*;

  // Calibration registers
  calib_t calib_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SENS:      calib_q.c1 <= cfg_data_i;
        REG_OFFSET:    calib_q.c2 <= cfg_data_i;
        REG_SENS_TC:   calib_q.c3 <= cfg_data_i;
        REG_OFFSET_TC: calib_q.c4 <= cfg_data_i;
        REG_TREF:      calib_q.c5 <= cfg_data_i;
        REG_TEMP_TC:   calib_q.c6 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline sections
  logic   front_valid, front_ready, corr_valid, corr_ready;
  front_t front_data;
  comp_t  corr_data;
  logic [TOUT_W-1:0] temp_out;
  logic [POUT_W-1:0] press_out;

  psc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .calib_i     (calib_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .d1_i        (s_axis_tdata[RAW_W-1:0]),
    .d2_i        (s_axis_tdata[2*RAW_W-1:RAW_W]),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_o       (front_data)
  );

  psc_corr u_corr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front_data),
    .out_valid_o (corr_valid),
    .out_ready_i (corr_ready),
    .out_o       (corr_data)
  );

  psc_press u_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (corr_valid),
    .in_ready_o  (corr_ready),
    .in_i        (corr_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .temp_o      (temp_out),
    .press_o     (press_out)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-TOUT_W-POUT_W){1'b0}}, press_out, temp_out};

  // Input back-pressure only ever comes from a stalled, full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  // Delivered temperature stays in the saturation window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[TOUT_W-1:0]) >= $signed(TEMP_OUT_MIN[TOUT_W-1:0])) &&
      ($signed(m_axis_tdata[TOUT_W-1:0]) <= $signed(TEMP_OUT_MAX[TOUT_W-1:0])))
    else $error("temperature outside saturation range");

  // Padding bits of the result stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:TOUT_W+POUT_W] == '0))
    else $error("result padding not zero");

endmodule

### src/psc_front.sv
module psc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psc_pkg::calib_t       calib_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [psc_pkg::RAW_W-1:0] d1_i,
  input  logic [psc_pkg::RAW_W-1:0] d2_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output psc_pkg::front_t       out_o
);
  import psc_pkg::*;

  logic [FRONT_STAGES-1:0] vld_q;
  logic [FRONT_STAGES:0]   rdy;

  // Per-stage ready: a stage loads when empty or when it drains
  always_comb begin
    rdy[FRONT_STAGES] = out_ready_i;
    for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[FRONT_STAGES-1];

  // Stage 1: dT
  logic signed [DT_W-1:0] dt_d, s1_dt_q;
  logic [RAW_W-1:0]       s1_d1_q;

  assign dt_d = $signed({1'b0, d2_i}) - $signed({1'b0, calib_i.c5, {TREF_SHIFT{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_dt_q <= dt_d;
      s1_d1_q <= d1_i;
    end
  end

  // Stage 2: coefficient products and dT squared
  logic signed [PT_W-1:0]  p_temp_d, p_off_d, p_sens_d;
  logic signed [PT_W-1:0]  p_temp_q, p_off_q, p_sens_q;
  logic signed [DT2_W-1:0] p_dt2_d, p_dt2_q;
  logic [RAW_W-1:0]        s2_d1_q;

  assign p_temp_d = s1_dt_q * $signed({1'b0, calib_i.c6});
  assign p_off_d  = s1_dt_q * $signed({1'b0, calib_i.c4});
  assign p_sens_d = s1_dt_q * $signed({1'b0, calib_i.c3});
  assign p_dt2_d  = s1_dt_q * s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      p_temp_q <= p_temp_d;
      p_off_q  <= p_off_d;
      p_sens_q <= p_sens_d;
      p_dt2_q  <= p_dt2_d;
      s2_d1_q  <= s1_d1_q;
    end
  end

  // Stage 3: first-order TEMP, OFF, SENS and T2 (floor shifts)
  logic signed [PT_W-1:0]   temp_w, off_w, sens_w;
  front_t                   out_d, out_q;

  assign temp_w = (p_temp_q >>> TEMP_SHIFT) + PT_W'(TEMP_REF);
  assign off_w  = (p_off_q >>> OFF_TC_SHIFT)
                + $signed(PT_W'({calib_i.c2, {OFF_SHIFT{1'b0}}}));
  assign sens_w = (p_sens_q >>> SENS_TC_SHIFT)
                + $signed(PT_W'({calib_i.c1, {SENS_SHIFT{1'b0}}}));

  always_comb begin
    out_d.d1   = s2_d1_q;
    out_d.temp = temp_w[TEMP_W-1:0];
    out_d.t2   = p_dt2_q[T2_SHIFT +: T2_W];
    out_d.off  = off_w[WIDE_W-1:0];
    out_d.sens = sens_w[WIDE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

### src/psc_corr.sv
module psc_corr (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  psc_pkg::front_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output psc_pkg::comp_t  out_o
);
  import psc_pkg::*;

  logic [CORR_STAGES-1:0] vld_q;
  logic [CORR_STAGES:0]   rdy;

  always_comb begin
    rdy[CORR_STAGES] = out_ready_i;
    for (int k = CORR_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < CORR_STAGES; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[CORR_STAGES-1];

  // Stage 1: deltas from the two thresholds
  front_t                   s1_q, s2_q, s3_q;
  logic signed [TEMP_W-1:0] a_q, b_q;
  logic                     cold_q, frigid_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_q     <= in_i;
      a_q      <= $signed(in_i.temp) - TEMP_REF;
      b_q      <= $signed(in_i.temp) - TEMP_COLD;
      cold_q   <= $signed(in_i.temp) < TEMP_REF;
      frigid_q <= $signed(in_i.temp) < TEMP_COLD;
    end
  end

  // Stage 2: squares
  logic signed [SQ_W-1:0] sq_d, sq2_d;
  logic [SQ_W-1:0]        sq_q, sq2_q;
  logic                   cold2_q, frigid2_q;

  assign sq_d  = a_q * a_q;
  assign sq2_d = b_q * b_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_q      <= s1_q;
      sq_q      <= sq_d;
      sq2_q     <= sq2_d;
      cold2_q   <= cold_q;
      frigid2_q <= frigid_q;
    end
  end

  // Stage 3: OFF2, SENS2, T2 (zero above the reference temperature)
  logic [WIDE_W-1:0] off2_base, sens2_base, off2_cold, sens2_cold;
  logic [WIDE_W-1:0] off2_d, sens2_d, off2_q, sens2_q;
  logic [T2_W-1:0]   t2_d;
  front_t            s3_d;

  assign off2_base  = (WIDE_W'(sq_q) * OFF2_GAIN) >> OFF2_SHIFT;
  assign sens2_base = WIDE_W'(sq_q) << 1;
  assign off2_cold  = WIDE_W'(sq2_q) * OFF2_COLD_GAIN;
  assign sens2_cold = WIDE_W'(sq2_q) * SENS2_COLD_GAIN;

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    t2_d    = '0;
    if (cold2_q) begin
      t2_d    = s2_q.t2;
      off2_d  = frigid2_q ? off2_base + off2_cold : off2_base;
      sens2_d = frigid2_q ? sens2_base + sens2_cold : sens2_base;
    end
    s3_d    = s2_q;
    s3_d.t2 = t2_d;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_q    <= s3_d;
      off2_q  <= off2_d;
      sens2_q <= sens2_d;
    end
  end

  // Stage 4: apply corrections
  comp_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      out_q.d1   <= s3_q.d1;
      out_q.temp <= $signed(s3_q.temp) - $signed(TEMP_W'(s3_q.t2));
      out_q.off  <= $signed(s3_q.off) - $signed(off2_q);
      out_q.sens <= $signed(s3_q.sens) - $signed(sens2_q);
    end
  end

  assign out_o = out_q;

endmodule

### src/psc_press.sv
module psc_press (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  psc_pkg::comp_t             in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [psc_pkg::TOUT_W-1:0] temp_o,
  output logic [psc_pkg::POUT_W-1:0] press_o
);
  import psc_pkg::*;

  logic [PRESS_STAGES-1:0] vld_q;
  logic [PRESS_STAGES:0]   rdy;

  always_comb begin
    rdy[PRESS_STAGES] = out_ready_i;
    for (int k = PRESS_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < PRESS_STAGES; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[PRESS_STAGES-1];

  // Stage 1: D1*SENS as two partial products
  logic [SENS_LO_W-1:0]        sens_lo;
  logic signed [SENS_HI_W-1:0] sens_hi;
  logic [PP_LO_W-1:0]          pp_lo_d, pp_lo_q;
  logic signed [PP_HI_W-1:0]   pp_hi_d, pp_hi_q;
  logic signed [WIDE_W-1:0]    s1_off_q, s2_off_q;
  logic signed [TEMP_W-1:0]    s1_temp_q, s2_temp_q;

  assign sens_lo = in_i.sens[SENS_LO_W-1:0];
  assign sens_hi = in_i.sens[WIDE_W-1:SENS_LO_W];
  assign pp_lo_d = PP_LO_W'(in_i.d1) * PP_LO_W'(sens_lo);
  assign pp_hi_d = $signed({1'b0, in_i.d1}) * sens_hi;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pp_lo_q   <= pp_lo_d;
      pp_hi_q   <= pp_hi_d;
      s1_off_q  <= in_i.off;
      s1_temp_q <= in_i.temp;
    end
  end

  // Stage 2: combine partial products, floor shift by 2^21
  logic signed [PROD_W-1:0]   prod_w;
  logic signed [SCALED_W-1:0] scaled_q;

  assign prod_w = (PROD_W'(pp_hi_q) <<< SENS_LO_W) + $signed(PROD_W'(pp_lo_q));

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      scaled_q  <= prod_w[PROD_SHIFT +: SCALED_W];
      s2_off_q  <= s1_off_q;
      s2_temp_q <= s1_temp_q;
    end
  end

  // Stage 3: subtract OFF, floor shift by 2^15, saturate both outputs
  logic signed [DIFF_W-1:0]   diff_w;
  logic signed [PSHIFT_W-1:0] p_w;
  logic [POUT_W-1:0]          press_d, press_q;
  logic [TOUT_W-1:0]          temp_d, temp_q;

  assign diff_w = DIFF_W'(scaled_q) - DIFF_W'(s2_off_q);
  assign p_w    = diff_w[DIFF_W-1:PRESS_SHIFT];

  always_comb begin
    if (p_w < 0) begin
      press_d = '0;
    end else if (p_w > $signed({{(PSHIFT_W-POUT_W){1'b0}}, PRESS_OUT_MAX})) begin
      press_d = PRESS_OUT_MAX;
    end else begin
      press_d = p_w[POUT_W-1:0];
    end
    if (s2_temp_q < TEMP_OUT_MIN) begin
      temp_d = TEMP_OUT_MIN[TOUT_W-1:0];
    end else if (s2_temp_q > TEMP_OUT_MAX) begin
      temp_d = TEMP_OUT_MAX[TOUT_W-1:0];
    end else begin
      temp_d = s2_temp_q[TOUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      press_q <= press_d;
      temp_q  <= temp_d;
    end
  end

  assign temp_o  = temp_q;
  assign press_o = press_q;

endmodule
